// ----- src/sbc_pkg.sv -----
package sbc_pkg;

	localparam int ROUNDS = 32;
	localparam int KEY_GROUPS = ROUNDS + 1;
	localparam int KEY_WORDS = 4 * KEY_GROUPS;
	localparam int PRE_IDX_W = $clog2(KEY_WORDS);
	localparam int GRP_W = $clog2(KEY_GROUPS);
	localparam logic [31:0] GOLDEN = 32'h9E3779B9;

	localparam logic [0:0] OP_ENCRYPT = 1'b0;
	localparam logic [0:0] OP_DECRYPT = 1'b1;

	localparam logic [0:0] REG_KEY_LOW = 1'b0;
	localparam logic [0:0] REG_KEY_HIGH = 1'b1;

	typedef logic [31:0] word_t;
	typedef word_t [3:0] block_t;

	// Forward S-box lookup for one nibble.
	function automatic logic [3:0] sbox_fwd(input logic [2:0] box, input logic [3:0] nib);
		logic [63:0] row;
		begin
			case (box)
				3'd0: row = 64'hC90724DEB56A1F83;
				3'd1: row = 64'h43D68EB1A50972CF;
				3'd2: row = 64'h25B04E1DFAC39768;
				3'd3: row = 64'hE57A421D369C8BF0;
				3'd4: row = 64'hD7E9A4526B0C38F1;
				3'd5: row = 64'h176D8E30C9A4B25F;
				3'd6: row = 64'h0A3DF19EB6485C27;
				3'd7: row = 64'h6539AC47B28E0FD1;
				default: row = 64'h0;
			endcase
			sbox_fwd = row[{nib, 2'b00} +: 4];
		end
	endfunction

	// Inverse S-box lookup, found by matching the forward table.
	function automatic logic [3:0] sbox_inv(input logic [2:0] box, input logic [3:0] nib);
		logic [3:0] res;
		begin
			res = 4'd0;
			for (int j = 0; j < 16; j++) begin
				if (sbox_fwd(box, 4'(j)) == nib) begin
					res = 4'(j);
				end
			end
			sbox_inv = res;
		end
	endfunction

	// Bitsliced S-box over four words.
	function automatic block_t sbox_words(input block_t w, input logic [2:0] box,
		input logic inv);
		block_t o;
		logic [3:0] n;
		logic [3:0] r;
		begin
			o = '0;
			for (int b = 0; b < 32; b++) begin
				n = {w[3][b], w[2][b], w[1][b], w[0][b]};
				r = inv ? sbox_inv(box, n) : sbox_fwd(box, n);
				o[0][b] = r[0];
				o[1][b] = r[1];
				o[2][b] = r[2];
				o[3][b] = r[3];
			end
			sbox_words = o;
		end
	endfunction

	function automatic word_t rol(input word_t v, input int n);
		rol = (v << n) | (v >> (32 - n));
	endfunction

	function automatic block_t lin_fwd(input block_t wi);
		block_t w;
		begin
			w = wi;
			w[0] = rol(w[0], 13);
			w[2] = rol(w[2], 3);
			w[1] = w[1] ^ w[0] ^ w[2];
			w[3] = w[3] ^ w[2] ^ (w[0] << 3);
			w[1] = rol(w[1], 1);
			w[3] = rol(w[3], 7);
			w[0] = w[0] ^ w[1] ^ w[3];
			w[2] = w[2] ^ w[3] ^ (w[1] << 7);
			w[0] = rol(w[0], 5);
			w[2] = rol(w[2], 22);
			lin_fwd = w;
		end
	endfunction

	function automatic block_t lin_inv(input block_t wi);
		block_t w;
		begin
			w = wi;
			w[2] = rol(w[2], 10);
			w[0] = rol(w[0], 27);
			w[2] = w[2] ^ w[3] ^ (w[1] << 7);
			w[0] = w[0] ^ w[1] ^ w[3];
			w[3] = rol(w[3], 25);
			w[1] = rol(w[1], 31);
			w[3] = w[3] ^ w[2] ^ (w[0] << 3);
			w[1] = w[1] ^ w[0] ^ w[2];
			w[2] = rol(w[2], 29);
			w[0] = rol(w[0], 19);
			lin_inv = w;
		end
	endfunction

endpackage

// ----- src/sbc_key_sched.sv -----
module sbc_key_sched
	import sbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [63:0]          key_low,
	input  logic [63:0]          key_high,
	output logic                 busy,
	output logic                 wr_en,
	output logic [GRP_W-1:0]     wr_grp,
	output block_t               wr_data
);

	localparam logic [1:0] KS_IDLE = 2'd0;
	localparam logic [1:0] KS_WORD = 2'd1;
	localparam logic [1:0] KS_SBOX = 2'd2;

	logic [1:0]           state_q;
	logic [31:0]          win_q [8];
	logic [1:0]           sub_q;
	logic [GRP_W-1:0]     grp_q;
	block_t               grp_words_q;
	logic [PRE_IDX_W-1:0] idx_q;
	word_t                next_w;
	word_t                mix_w;

	// One prekey word per cycle from the sliding window of eight, while in the word state.
	assign mix_w = win_q[0] ^ win_q[3] ^ win_q[5] ^ win_q[7] ^ GOLDEN
		^ 32'(idx_q);
	assign next_w = rol(mix_w, 11);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_WORD;
			sub_q   <= '0;
			grp_q   <= '0;
			idx_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				win_q[i] <= (i == 4) ? 32'd1 : 32'd0;
			end
		end else if (start) begin
			// A new key restarts the expansion from any state.
			state_q  <= KS_WORD;
			sub_q    <= '0;
			grp_q    <= '0;
			idx_q    <= '0;
			win_q[0] <= key_low[31:0];
			win_q[1] <= key_low[63:32];
			win_q[2] <= key_high[31:0];
			win_q[3] <= key_high[63:32];
			win_q[4] <= 32'd1;
			win_q[5] <= '0;
			win_q[6] <= '0;
			win_q[7] <= '0;
		end else begin
			case (state_q)
				KS_IDLE: begin
				end
				KS_WORD: begin
					for (int i = 0; i < 7; i++) begin
						win_q[i] <= win_q[i+1];
					end
					win_q[7] <= next_w;
					grp_words_q[sub_q] <= next_w;
					idx_q <= idx_q + 1'b1;
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd3) begin
						state_q <= KS_SBOX;
					end
				end
				KS_SBOX: begin
					grp_q <= grp_q + 1'b1;
					state_q <= (grp_q == GRP_W'(KEY_GROUPS - 1)) ? KS_IDLE : KS_WORD;
				end
				default: state_q <= KS_IDLE;
			endcase
		end
	end

	// Group S-box (3 - group) mod 8 at write time.
	assign busy    = (state_q != KS_IDLE);
	assign wr_en   = (state_q == KS_SBOX);
	assign wr_grp  = grp_q;
	assign wr_data = sbox_words(grp_words_q, 3'(3 - grp_q[2:0]), 1'b0);

endmodule

// ----- src/serpent_block_cipher.sv -----
// Serpent-128 cipher, one 128-bit block per transaction, encrypt or decrypt
// chosen by operation. An accepted block runs through all 32 rounds plus
// the final key mix in the shared round unit, one round key group read from
// the store per cycle, and the result is then held until taken; the next
// block is accepted once the result leaves. After reset and after any key
// write the round key store is rebuilt, four prekey words and then one
// S-box write per key group (after a key write the start first registers),
// during which no block is accepted.
module serpent_block_cipher
	import sbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [63:0] block_low,
	input  logic [63:0] block_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_low,
	output logic [63:0] result_high
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [63:0]      key_low_q;
	logic [63:0]      key_high_q;
	logic             ks_start_q;
	logic             ks_busy;
	logic             ks_wr_en;
	logic [GRP_W-1:0] ks_wr_grp;
	block_t           ks_wr_data;

	block_t           rk_mem [KEY_GROUPS];
	block_t           rk_rd_q;
	logic [GRP_W-1:0] rd_grp;

	logic [1:0]       state_q;
	logic             op_q;
	logic             first_q;
	logic [GRP_W-1:0] step_q;
	block_t           data_q;
	block_t           round_out;
	logic [GRP_W-1:0] cur_round;

	// Key registers; any write restarts the schedule.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			ks_start_q <= 1'b0;
		end else begin
			ks_start_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_LOW:  key_low_q <= cfg_data;
					REG_KEY_HIGH: key_high_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	sbc_key_sched u_ks (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ks_start_q),
		.key_low  (key_low_q),
		.key_high (key_high_q),
		.busy     (ks_busy),
		.wr_en    (ks_wr_en),
		.wr_grp   (ks_wr_grp),
		.wr_data  (ks_wr_data)
	);

	// Round key store, one group of four words per entry.
	always_ff @(posedge clk) begin
		if (ks_wr_en) begin
			rk_mem[ks_wr_grp] <= ks_wr_data;
		end
		rk_rd_q <= rk_mem[rd_grp];
	end

	// Read address: the group needed on the next cycle.
	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_grp = (operation == OP_DECRYPT) ? GRP_W'(ROUNDS) : '0;
		end else if (op_q == OP_DECRYPT) begin
			rd_grp = GRP_W'(ROUNDS - 1) - step_q;
		end else begin
			rd_grp = step_q + 1'b1;
		end
	end

	// Shared round unit. Encrypt step r: key mix, S-box, transform or
	// nothing on the last round; step 32 is the final key mix. Decrypt step
	// 0 is the first key mix; step k applies round 32-k inverted.
	assign cur_round = (op_q == OP_DECRYPT) ? GRP_W'(ROUNDS) - step_q : step_q;
	always_comb begin
		block_t t;
		t = data_q;
		if (op_q == OP_ENCRYPT) begin
			t = t ^ rk_rd_q;
			if (step_q != GRP_W'(ROUNDS)) begin
				t = sbox_words(t, cur_round[2:0], 1'b0);
				if (step_q != GRP_W'(ROUNDS - 1)) begin
					t = lin_fwd(t);
				end
			end
		end else begin
			if (step_q != '0) begin
				if (step_q != 6'(1)) begin
					t = lin_inv(t);
				end
				t = sbox_words(t, cur_round[2:0], 1'b1);
			end
			t = t ^ rk_rd_q;
		end
		round_out = t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			first_q <= 1'b0;
			op_q    <= OP_ENCRYPT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						state_q <= ST_RUN;
						op_q    <= operation;
						step_q  <= '0;
						first_q <= 1'b1;
					end
				end
				ST_RUN: begin
					first_q <= 1'b0;
					if (step_q == GRP_W'(ROUNDS)) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Data path register.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			data_q <= {block_high[63:32], block_high[31:0], block_low[63:32], block_low[31:0]};
		end else if (state_q == ST_RUN) begin
			data_q <= round_out;
		end
	end

	assign in_stall    = (state_q != ST_IDLE) || ks_busy || ks_start_q || cfg_we;
	assign out_valid   = (state_q == ST_DONE);
	assign result_low  = {data_q[1], data_q[0]};
	assign result_high = {data_q[3], data_q[2]};

	// A result appears only after a full round sequence.
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && step_q == GRP_W'(ROUNDS)) |=> out_valid)
		else $error("result not presented after final step");
	a_no_start_in_sched: assert property (@(posedge clk) disable iff (!arst_n)
		ks_busy |-> in_stall)
		else $error("block accepted during key schedule");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q <= GRP_W'(ROUNDS)))
		else $error("round counter out of range");
	a_first_step: assert property (@(posedge clk) disable iff (!arst_n)
		first_q |-> (step_q == '0))
		else $error("first step flag out of step");

endmodule

// ----- tb/serpent_block_cipher_tb.sv -----
`timescale 1ns / 1ps

module serpent_block_cipher_tb;
	import sbc_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [0:0]  op;
		logic [63:0] lo;
		logic [63:0] hi;
	} stim_row_t;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
	} cipher_out_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [63:0] block_low;
	logic [63:0] block_high;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] result_low;
	logic [63:0] result_high;

	// Predictor state: key registers, expanded round keys and S-box tables.
	logic [63:0] key_lo_q;
	logic [63:0] key_hi_q;
	word_t       round_keys [KEY_WORDS];
	logic [3:0]  sbox_tab [8][16];
	logic [3:0]  sbox_rev [8][16];

	cipher_out_t expected_q [$];
	int          cycle_count;
	int          error_count;
	bit          hold_request;
	stim_row_t   directed [16];

	serpent_block_cipher DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.block_low  (block_low),
		.block_high (block_high),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result_low (result_low),
		.result_high(result_high)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic word_t rotl(input word_t v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// Bitsliced S-box: bit b of words 0..3 forms one nibble, word 0 as LSB.
	function automatic block_t slice_sbox(input block_t w, input int box, input bit inv);
		block_t o;
		logic [3:0] nib;
		logic [3:0] res;
		o = '0;
		for (int b = 0; b < 32; b++) begin
			nib = {w[3][b], w[2][b], w[1][b], w[0][b]};
			res = inv ? sbox_rev[box][nib] : sbox_tab[box][nib];
			for (int k = 0; k < 4; k++) o[k][b] = res[k];
		end
		return o;
	endfunction

	function automatic block_t mix_forward(input block_t wi);
		block_t w;
		w = wi;
		w[0] = rotl(w[0], 13);
		w[2] = rotl(w[2], 3);
		w[1] = w[1] ^ w[0] ^ w[2];
		w[3] = w[3] ^ w[2] ^ (w[0] << 3);
		w[1] = rotl(w[1], 1);
		w[3] = rotl(w[3], 7);
		w[0] = w[0] ^ w[1] ^ w[3];
		w[2] = w[2] ^ w[3] ^ (w[1] << 7);
		w[0] = rotl(w[0], 5);
		w[2] = rotl(w[2], 22);
		return w;
	endfunction

	function automatic block_t mix_backward(input block_t wi);
		block_t w;
		w = wi;
		w[2] = rotl(w[2], 32 - 22);
		w[0] = rotl(w[0], 32 - 5);
		w[2] = w[2] ^ w[3] ^ (w[1] << 7);
		w[0] = w[0] ^ w[1] ^ w[3];
		w[3] = rotl(w[3], 32 - 7);
		w[1] = rotl(w[1], 32 - 1);
		w[3] = w[3] ^ w[2] ^ (w[0] << 3);
		w[1] = w[1] ^ w[0] ^ w[2];
		w[2] = rotl(w[2], 32 - 3);
		w[0] = rotl(w[0], 32 - 13);
		return w;
	endfunction

	function automatic block_t add_round_key(input block_t w, input int grp);
		block_t o;
		for (int k = 0; k < 4; k++) o[k] = w[k] ^ round_keys[grp * 4 + k];
		return o;
	endfunction

	// Expands the 128-bit key, padded with a single one bit, into the round keys.
	function automatic void expand_key();
		word_t  pre [8 + KEY_WORDS];
		block_t g;
		pre[0] = key_lo_q[31:0];
		pre[1] = key_lo_q[63:32];
		pre[2] = key_hi_q[31:0];
		pre[3] = key_hi_q[63:32];
		pre[4] = 32'd1;
		pre[5] = 32'd0;
		pre[6] = 32'd0;
		pre[7] = 32'd0;
		for (int i = 0; i < KEY_WORDS; i++)
			pre[i + 8] = rotl(pre[i] ^ pre[i + 3] ^ pre[i + 5] ^ pre[i + 7] ^ GOLDEN ^ word_t'(i), 11);
		for (int i = 0; i < KEY_GROUPS; i++) begin
			for (int k = 0; k < 4; k++) g[k] = pre[8 + i * 4 + k];
			g = slice_sbox(g, (3 - i) & 7, 1'b0);
			for (int k = 0; k < 4; k++) round_keys[i * 4 + k] = g[k];
		end
	endfunction

	function automatic cipher_out_t serpent_result(input logic [0:0] op, input logic [63:0] lo,
		input logic [63:0] hi);
		block_t w;
		cipher_out_t r;
		w[0] = lo[31:0];
		w[1] = lo[63:32];
		w[2] = hi[31:0];
		w[3] = hi[63:32];
		if (op == OP_ENCRYPT) begin
			for (int rnd = 0; rnd < ROUNDS; rnd++) begin
				w = add_round_key(w, rnd);
				w = slice_sbox(w, rnd & 7, 1'b0);
				if (rnd < ROUNDS - 1) w = mix_forward(w);
			end
			w = add_round_key(w, ROUNDS);
		end else begin
			w = add_round_key(w, ROUNDS);
			for (int rnd = ROUNDS - 1; rnd >= 0; rnd--) begin
				if (rnd < ROUNDS - 1) w = mix_backward(w);
				w = slice_sbox(w, rnd & 7, 1'b1);
				w = add_round_key(w, rnd);
			end
		end
		r.lo = {w[1], w[0]};
		r.hi = {w[3], w[2]};
		return r;
	endfunction

	// Standard Serpent S0 to S7 and their inverses.
	initial begin
		int rows [8][16];
		rows = '{
			'{3, 8, 15, 1, 10, 6, 5, 11, 14, 13, 4, 2, 7, 0, 9, 12},
			'{15, 12, 2, 7, 9, 0, 5, 10, 1, 11, 14, 8, 6, 13, 3, 4},
			'{8, 6, 7, 9, 3, 12, 10, 15, 13, 1, 14, 4, 0, 11, 5, 2},
			'{0, 15, 11, 8, 12, 9, 6, 3, 13, 1, 2, 4, 10, 7, 5, 14},
			'{1, 15, 8, 3, 12, 0, 11, 6, 2, 5, 4, 10, 9, 14, 7, 13},
			'{15, 5, 2, 11, 4, 10, 9, 12, 0, 3, 14, 8, 13, 6, 7, 1},
			'{7, 2, 12, 5, 8, 4, 6, 11, 14, 9, 1, 15, 13, 3, 10, 0},
			'{1, 13, 15, 0, 14, 8, 2, 11, 7, 4, 12, 10, 9, 3, 5, 6}};
		for (int b = 0; b < 8; b++) begin
			for (int n = 0; n < 16; n++) begin
				sbox_tab[b][n] = 4'(rows[b][n]);
				sbox_rev[b][rows[b][n]] = 4'(n);
			end
		end
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Input side: predict each accepted block. Output side: check each result.
	always @(posedge clk) begin
		cipher_out_t exp_r;
		if (arst_n && in_valid && !in_stall)
			expected_q.push_back(serpent_result(operation, block_low, block_high));
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, actual %h_%h", $time, result_high, result_low);
				error_count++;
			end else begin
				exp_r = expected_q.pop_front();
				if (result_low !== exp_r.lo) begin
					$display("%0t: result_low expected %h actual %h", $time, exp_r.lo, result_low);
					error_count++;
				end
				if (result_high !== exp_r.hi) begin
					$display("%0t: result_high expected %h actual %h", $time, exp_r.hi,
						result_high);
					error_count++;
				end
			end
		end
	end

	// Receiver stall pattern of randomly chosen modes, plus one long hold-off.
	initial begin
		int mode;
		out_stall = 1'b0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			if (cycle_count % 64 == 0) mode = $urandom_range(0, 3);
			case (mode)
				0: out_stall = 1'b0;
				1: out_stall = ($urandom_range(0, 3) == 0);
				2: out_stall = ($urandom_range(0, 3) != 0);
				default: out_stall = ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	// Offers one block and holds it until accepted.
	task automatic send_block(input logic [0:0] op, input logic [63:0] lo, input logic [63:0] hi);
		in_valid = 1'b1;
		operation = op;
		block_low = lo;
		block_high = hi;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
	endtask

	// Key writes happen only with the block idle.
	task automatic write_key(input logic idx, input logic [63:0] value);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_KEY_LOW) key_lo_q = value;
		else key_hi_q = value;
		expand_key();
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Random blocks sent in bursts with gaps.
	task automatic random_phase(input int count, input bit with_hold);
		int burst;
		logic [63:0] lo;
		logic [63:0] hi;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(0, 12)) @(negedge clk);
				burst = $urandom_range(1, 10);
			end
			burst--;
			if (with_hold && i == count / 3) hold_request = 1'b1;
			if (i == count / 2) drain();
			case ($urandom_range(0, 7))
				0: begin lo = '0; hi = rand64(); end
				1: begin lo = '1; hi = 64'd1 << $urandom_range(0, 63); end
				default: begin lo = rand64(); hi = rand64(); end
			endcase
			send_block(1'($urandom_range(0, 1)), lo, hi);
		end
		in_valid = 1'b0;
	endtask

	initial begin
		cycle_count = 0;
		error_count = 0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_LOW;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_ENCRYPT;
		block_low = '0;
		block_high = '0;
		key_lo_q = '0;
		key_hi_q = '0;
		directed = '{
			'{OP_ENCRYPT, 64'h0, 64'h0},
			'{OP_DECRYPT, 64'h0, 64'h0},
			'{OP_ENCRYPT, '1, '1},
			'{OP_DECRYPT, '1, '1},
			'{OP_ENCRYPT, 64'h1, 64'h0},
			'{OP_ENCRYPT, 64'h0, 64'h8000_0000_0000_0000},
			'{OP_DECRYPT, 64'h1, 64'h0},
			'{OP_DECRYPT, 64'h0, 64'h8000_0000_0000_0000},
			'{OP_ENCRYPT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
			'{OP_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
			'{OP_ENCRYPT, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000},
			'{OP_DECRYPT, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF},
			'{OP_ENCRYPT, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908},
			'{OP_DECRYPT, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908},
			'{OP_ENCRYPT, 64'h8000_0000_0000_0000, 64'h1},
			'{OP_DECRYPT, 64'h8000_0000_0000_0000, 64'h1}};
		repeat (9) @(negedge clk);
		// The S-box tables are filled by now, so the round keys can be expanded.
		expand_key();
		arst_n = 1'b1;

		// Directed blocks under the all-zero key from reset, sent back to back.
		foreach (directed[i]) send_block(directed[i].op, directed[i].lo, directed[i].hi);

		// Key settings: all ones, random, then each half changed on its own.
		write_key(REG_KEY_LOW, '1);
		write_key(REG_KEY_HIGH, '1);
		foreach (directed[i]) if (i < 6) send_block(directed[i].op, directed[i].lo, directed[i].hi);
		random_phase(150, 1'b0);
		write_key(REG_KEY_LOW, rand64());
		write_key(REG_KEY_HIGH, rand64());
		random_phase(180, 1'b1);
		write_key(REG_KEY_LOW, rand64());
		random_phase(170, 1'b0);
		write_key(REG_KEY_HIGH, '0);
		write_key(REG_KEY_LOW, 64'h1);
		random_phase(160, 1'b0);

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0 && expected_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
